FILE: rtl/u2af_pkg.sv
// shared types, constants and the latin-1 fold table for the utf-8 to ascii folder
package u2af_pkg;

   // request and response payloads
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [6:0] ascii_char;
      logic       char_valid;
      logic       run_last;
      logic       string_end;
   } rsp_type;

   // replacement text of up to three characters, chars[0] goes first
   typedef struct packed {
      logic [1:0]      len;
      logic [2:0][6:0] chars;
   } text_type;

   // one queued job: the characters a request leaves after the limit, and its end mark
   typedef struct packed {
      logic [2:0][6:0] chars;
      logic [1:0]      count;
      logic            last;
   } job_type;

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
   localparam logic [7:0] MAX_OUT_RESET = 8'd127;

   localparam logic [7:0] LEAD_C3     = 8'hC3;
   localparam logic [7:0] LEAD_E2     = 8'hE2;
   localparam logic [7:0] CONT_80     = 8'h80;
   localparam logic [7:0] PUNCT_EN    = 8'h93;
   localparam logic [7:0] PUNCT_EM    = 8'h94;
   localparam logic [7:0] PUNCT_LSQ   = 8'h98;
   localparam logic [7:0] PUNCT_RSQ   = 8'h99;
   localparam logic [7:0] PUNCT_LDQ   = 8'h9C;
   localparam logic [7:0] PUNCT_RDQ   = 8'h9D;
   localparam logic [7:0] PUNCT_ELLIP = 8'hA6;

   localparam logic [6:0] CH_A      = 7'h41;
   localparam logic [6:0] CH_C      = 7'h43;
   localparam logic [6:0] CH_E      = 7'h45;
   localparam logic [6:0] CH_I      = 7'h49;
   localparam logic [6:0] CH_N      = 7'h4E;
   localparam logic [6:0] CH_O      = 7'h4F;
   localparam logic [6:0] CH_U      = 7'h55;
   localparam logic [6:0] CH_LOW_E  = 7'h65;
   localparam logic [6:0] CH_LOW_S  = 7'h73;
   localparam logic [6:0] CH_DASH   = 7'h2D;
   localparam logic [6:0] CH_APOS   = 7'h27;
   localparam logic [6:0] CH_QUOTE  = 7'h22;
   localparam logic [6:0] CH_DOT    = 7'h2E;
   localparam logic [6:0] CASE_STEP = 7'h20;

   function automatic text_type text_one(input logic [6:0] ch);
      text_type t;
      t          = '0;
      t.len      = 2'd1;
      t.chars[0] = ch;
      return t;
   endfunction

   function automatic text_type text_two(input logic [6:0] ch0, input logic [6:0] ch1);
      text_type t;
      t          = '0;
      t.len      = 2'd2;
      t.chars[0] = ch0;
      t.chars[1] = ch1;
      return t;
   endfunction

   // latin-1 code 0xC0 + code folded to ascii; lower half mirrors upper half, sharp s apart
   function automatic text_type fold_lookup(input logic [5:0] code);
      text_type   t;
      logic [6:0] off;
      off = code[5] ? CASE_STEP : 7'h00;
      t   = '0;
      unique case (code[4:0])
         5'd0, 5'd1, 5'd2, 5'd3, 5'd5: t = text_one(CH_A + off);
         5'd4:                          t = text_two(CH_A + off, CH_LOW_E);
         5'd7:                          t = text_one(CH_C + off);
         5'd8, 5'd9, 5'd10, 5'd11:      t = text_one(CH_E + off);
         5'd12, 5'd13, 5'd14, 5'd15:    t = text_one(CH_I + off);
         5'd17:                         t = text_one(CH_N + off);
         5'd18, 5'd19, 5'd20, 5'd21,
         5'd24:                         t = text_one(CH_O + off);
         5'd22:                         t = text_two(CH_O + off, CH_LOW_E);
         5'd25, 5'd26, 5'd27:           t = text_one(CH_U + off);
         5'd28:                         t = text_two(CH_U + off, CH_LOW_E);
         5'd31: begin
            // sharp s only; its lower-half twin folds to nothing
            if (!code[5]) begin
               t = text_two(CH_LOW_S, CH_LOW_S);
            end
         end
         default:                       t = '0;
      endcase
      return t;
   endfunction

endpackage

FILE: rtl/utf8_to_ascii_folder_top.sv
// top level of the utf-8 to ascii folder
//
// request channel (req_valid/req_ready/req_data): one utf-8 byte per request,
//   end_of_string set on the final byte of a string
// response channel (rsp_valid/rsp_ready/rsp_data): zero to three responses
//   per request; run_last marks the last one a request causes, string_end
//   the one that closes a string (sent empty if the last byte gives nothing)
// csr_we/csr_wdata: writes the per-string character limit, reset value 127
// path: a taken request is written into the job queue, and its first response
//   is then loaded from the queue head into the response register
// throughput: one response per cycle from the back end while rsp_ready
//   does not stall it, at most three per request; requests that give
//   nothing put no job in the queue
// the front end decodes and keeps taking requests while the job queue has
//   room; a stalled rsp_ready only holds the response register and lets the
//   queue fill, after which req_ready drops
// reset: synchronous, clears decode state, count, queue, response valid and
//   character index and sets the limit to 127
module utf8_to_ascii_folder_top
   import u2af_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);

   // job handoff between decoder and expander
   logic             push;
   job_type          push_job;
   logic             pop;
   job_type          head_job;
   queue_status_type q_status;

   // decoder: utf-8 state, limit register and running count
   u2af_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_status  (q_status),
      .push      (push),
      .push_job  (push_job)
   );

   // decouples the two sides so each can stall on its own
   u2af_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   // expander: walks a job's characters into the response register
   u2af_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/u2af_front.sv
// front end: takes requests, decodes utf-8, applies the character limit
module u2af_front
   import u2af_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   input  logic             csr_we,
   input  logic [7:0]       csr_wdata,
   input  queue_status_type q_status,
   output logic             push,
   output job_type          push_job
);

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_C3   = 3'd1,
      MODE_E2   = 3'd2,
      MODE_E280 = 3'd3,
      MODE_SKIP = 3'd4
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic [7:0] cw_ff, cw_in;
   logic [7:0] max_ff;

   logic       accept;
   logic       fresh;
   logic       is_cont;
   text_type   text;
   logic [7:0] room;
   logic [1:0] n_out;
   logic [7:0] b;

   assign b         = req_data.in_byte;
   assign is_cont   = (b[7:6] == 2'b10);
   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      text    = '0;
      mode_in = MODE_IDLE;
      fresh   = 1'b0;
      unique case (mode_ff)
         MODE_C3: text = fold_lookup(b[5:0]);
         MODE_E2: begin
            if (b == CONT_80) begin
               mode_in = MODE_E280;
            end else if (is_cont) begin
               mode_in = MODE_SKIP;
            end else begin
               fresh = 1'b1;
            end
         end
         MODE_E280: begin
            if (b == PUNCT_EN || b == PUNCT_EM) begin
               text = text_one(CH_DASH);
            end else if (b == PUNCT_LSQ || b == PUNCT_RSQ) begin
               text = text_one(CH_APOS);
            end else if (b == PUNCT_LDQ || b == PUNCT_RDQ) begin
               text = text_one(CH_QUOTE);
            end else if (b == PUNCT_ELLIP) begin
               text.len      = 2'd3;
               text.chars[0] = CH_DOT;
               text.chars[1] = CH_DOT;
               text.chars[2] = CH_DOT;
            end
         end
         MODE_SKIP: begin
            if (is_cont) begin
               mode_in = MODE_SKIP;
            end else begin
               fresh = 1'b1;
            end
         end
         default: fresh = 1'b1;
      endcase

      if (fresh) begin
         priority if (!b[7]) begin
            text = text_one(b[6:0]);
         end else if (b == LEAD_C3) begin
            mode_in = MODE_C3;
         end else if (b == LEAD_E2) begin
            mode_in = MODE_E2;
         end else begin
            mode_in = MODE_SKIP;
         end
      end

      if (req_data.end_of_string) begin
         mode_in = MODE_IDLE;
      end
   end

   // characters left under the limit; a replacement is cut to that
   assign room  = (cw_ff < max_ff) ? (max_ff - cw_ff) : 8'd0;
   assign n_out = (room < {6'd0, text.len}) ? room[1:0] : text.len;
   assign cw_in = req_data.end_of_string ? 8'd0 : (cw_ff + {6'd0, n_out});

   assign push           = accept && ((n_out != 2'd0) || req_data.end_of_string);
   assign push_job.chars = text.chars;
   assign push_job.count = n_out;
   assign push_job.last  = req_data.end_of_string;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         cw_ff   <= 8'd0;
         max_ff  <= MAX_OUT_RESET;
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
            cw_ff   <= cw_in;
         end
         if (csr_we) begin
            max_ff <= csr_wdata;
         end
      end
   end

endmodule

FILE: rtl/u2af_queue.sv
// short job queue between front and back
module u2af_queue
   import u2af_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type q_status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_job       = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : (wr_ptr_ff + 1'b1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : (rd_ptr_ff + 1'b1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: rtl/u2af_back.sv
// back end: expands queued jobs into one response per cycle unless rsp_ready stalls it
module u2af_back
   import u2af_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  job_type          head_job,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   logic       rsp_valid_ff;
   rsp_type    rsp_ff, rsp_in;
   logic [1:0] idx_ff;
   logic       load;
   logic       take;
   logic       at_end;

   assign load   = !rsp_valid_ff || rsp_ready;
   assign take   = load && !q_status.empty;
   assign at_end = (head_job.count == 2'd0) || (idx_ff == head_job.count - 2'd1);
   assign pop    = take && at_end;

   always_comb begin
      rsp_in = '0;
      if (head_job.count == 2'd0) begin
         // string closed with no character left: empty closing response
         rsp_in.run_last   = 1'b1;
         rsp_in.string_end = 1'b1;
      end else begin
         rsp_in.ascii_char = head_job.chars[idx_ff];
         rsp_in.char_valid = 1'b1;
         rsp_in.run_last   = at_end;
         rsp_in.string_end = at_end && head_job.last;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         if (load) begin
            rsp_valid_ff <= !q_status.empty;
         end
         if (take) begin
            idx_ff <= at_end ? 2'd0 : (idx_ff + 2'd1);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/u2af_checker.sv
// port-level checks for the utf-8 to ascii folder, bound to the top level
module u2af_checker
   import u2af_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // response held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   // closing response is always the last of its request
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.string_end |-> rsp_data.run_last)
      else $error("string end without run last");

   // an empty response only closes a string and carries no character
   a_empty_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.char_valid |->
         rsp_data.string_end && (rsp_data.ascii_char == 7'd0))
      else $error("empty response that does not close a string");

   // nothing shown right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind utf8_to_ascii_folder_top u2af_checker u_checker (.*);

FILE: bench/tb_utf8_to_ascii_folder_top.sv
// testbench for utf8_to_ascii_folder_top: directed and random byte strings checked against a fold predictor
`timescale 1ns / 100ps

module tb_utf8_to_ascii_folder_top;
   import u2af_pkg::*;

   // share of cycles in which either side idles
   localparam int IDLE_PCT     = 16;
   // receiver hold-off long enough to fill the job queue several times over
   localparam int HOLD_CYCLES  = 80;
   // quiet cycles after the last response before touching the limit
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 30;

   // decoder phases of the predictor
   typedef enum logic [2:0] {
      DEC_IDLE,
      DEC_AFTER_C3,
      DEC_AFTER_E2,
      DEC_AFTER_E280,
      DEC_SKIP
   } dec_state_type;

   typedef logic [7:0] byte_queue_type[$];

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_data;
   logic       csr_we;
   logic [7:0] csr_wdata;

   // predictor state: decode phase, characters so far in the string, limit
   dec_state_type pred_mode;
   logic [7:0] pred_count;
   logic [7:0] pred_limit;
   rsp_type    out_buf[3];
   int         n_out;

   // folded characters still owed by the block, oldest first
   rsp_type    expected_chars[$];
   rsp_type    exp_rsp;
   int         errors;
   int         requests_sent;

   // idling switch shared by both sides; hold-off asks and the ones the receiver has run
   bit         idle_on;
   int         hold_asks;
   int         hold_done;
   int         hold_left;

   utf8_to_ascii_folder_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // fold predictor
   // ---------------------------------------------------------------

   // latin-1 code 0xC0 + code spelt in plain ascii
   function automatic string latin_fold_text(input logic [5:0] code);
      case (code)
         6'd0, 6'd1, 6'd2, 6'd3, 6'd5:     return "A";
         6'd4:                             return "Ae";
         6'd7:                             return "C";
         6'd8, 6'd9, 6'd10, 6'd11:         return "E";
         6'd12, 6'd13, 6'd14, 6'd15:       return "I";
         6'd17:                            return "N";
         6'd18, 6'd19, 6'd20, 6'd21, 6'd24: return "O";
         6'd22:                            return "Oe";
         6'd25, 6'd26, 6'd27:              return "U";
         6'd28:                            return "Ue";
         6'd31:                            return "ss";
         6'd32, 6'd33, 6'd34, 6'd35, 6'd37: return "a";
         6'd36:                            return "ae";
         6'd39:                            return "c";
         6'd40, 6'd41, 6'd42, 6'd43:       return "e";
         6'd44, 6'd45, 6'd46, 6'd47:       return "i";
         6'd49:                            return "n";
         6'd50, 6'd51, 6'd52, 6'd53, 6'd56: return "o";
         6'd54:                            return "oe";
         6'd57, 6'd58, 6'd59:              return "u";
         6'd60:                            return "ue";
         default:                          return "";
      endcase
   endfunction

   // one character, dropped once the string has hit its limit
   function automatic void put_char(input logic [6:0] ch);
      if (pred_count >= pred_limit || n_out >= 3) begin
         return;
      end
      out_buf[n_out] = '{ascii_char: ch, char_valid: 1'b1, run_last: 1'b0, string_end: 1'b0};
      n_out++;
      pred_count++;
   endfunction

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         put_char(7'(s[i]));
      end
   endfunction

   function automatic bit is_cont(input logic [7:0] b);
      return b[7:6] == 2'b10;
   endfunction

   // a byte seen with no sequence open
   function automatic void fold_fresh(input logic [7:0] b);
      if (b < CONT_80) begin
         put_char(b[6:0]);
      end else if (b == LEAD_C3) begin
         pred_mode = DEC_AFTER_C3;
      end else if (b == LEAD_E2) begin
         pred_mode = DEC_AFTER_E2;
      end else begin
         pred_mode = DEC_SKIP;
      end
   endfunction

   // work out the responses one accepted request causes
   function automatic void fold_request(input req_type r);
      dec_state_type prev;
      logic [7:0] b;
      prev      = pred_mode;
      b         = r.in_byte;
      pred_mode = DEC_IDLE;
      n_out     = 0;
      case (prev)
         DEC_AFTER_C3: put_text(latin_fold_text(b[5:0]));
         DEC_AFTER_E2: begin
            if (b == CONT_80) begin
               pred_mode = DEC_AFTER_E280;
            end else if (is_cont(b)) begin
               pred_mode = DEC_SKIP;
            end else begin
               fold_fresh(b);
            end
         end
         DEC_AFTER_E280: begin
            case (b)
               PUNCT_EN, PUNCT_EM:   put_text("-");
               PUNCT_LSQ, PUNCT_RSQ: put_text("'");
               PUNCT_LDQ, PUNCT_RDQ: put_text("\"");
               PUNCT_ELLIP:          put_text("...");
               default: ;
            endcase
         end
         DEC_SKIP: begin
            if (is_cont(b)) begin
               pred_mode = DEC_SKIP;
            end else begin
               fold_fresh(b);
            end
         end
         default: fold_fresh(b);
      endcase
      // final byte: always one response carrying the string end, empty if need be
      if (r.end_of_string) begin
         if (n_out == 0) begin
            out_buf[0] = '0;
            n_out      = 1;
         end
         out_buf[n_out-1].string_end = 1'b1;
         pred_mode  = DEC_IDLE;
         pred_count = '0;
      end
      if (n_out > 0) begin
         out_buf[n_out-1].run_last = 1'b1;
      end
      for (int i = 0; i < n_out; i++) begin
         expected_chars.push_back(out_buf[i]);
      end
   endfunction

   // ---------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------

   // ready changes on the falling edge; a hold-off runs its full length here
   initial begin
      rsp_ready = 1'b0;
      hold_done = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_done != hold_asks) begin
            hold_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on) begin
            rsp_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   // every accepted response is matched against the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: response with none owed, expected none actual %h", $time, rsp_data);
            errors++;
         end else begin
            exp_rsp = expected_chars.pop_front();
            check_field("ascii_char", exp_rsp.ascii_char, rsp_data.ascii_char);
            check_field("char_valid", exp_rsp.char_valid, rsp_data.char_valid);
            check_field("run_last", exp_rsp.run_last, rsp_data.run_last);
            check_field("string_end", exp_rsp.string_end, rsp_data.string_end);
         end
      end
   end

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------

   // offer one byte, holding it until taken; may idle first while idling is on
   task automatic send_request(input logic [7:0] b, input bit eos);
      req_type r;
      r.in_byte       = b;
      r.end_of_string = eos;
      while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      fold_request(r);
      requests_sent++;
   endtask

   // a byte string; the last byte closes it unless told otherwise
   task automatic send_string(input byte_queue_type s, input bit close = 1'b1);
      for (int i = 0; i < s.size(); i++) begin
         send_request(s[i], close && (i == s.size() - 1));
      end
   endtask

   // drop valid and wait for every owed response
   task automatic wait_all_chars_out();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // limit write, only with the block drained and quiet
   task automatic write_char_limit(input logic [7:0] value);
      wait_all_chars_out();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      pred_limit = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // one random piece of utf-8, mostly well formed, some broken or noise
   function automatic void add_random_piece(ref byte_queue_type s);
      logic [7:0] punct[7];
      logic [7:0] lead;
      int         pick;
      int         n_cont;
      punct = '{PUNCT_EN, PUNCT_EM, PUNCT_LSQ, PUNCT_RSQ, PUNCT_LDQ, PUNCT_RDQ, PUNCT_ELLIP};
      pick  = $urandom_range(0, 99);
      if (pick < 35) begin
         s.push_back(8'($urandom_range(0, 127)));
      end else if (pick < 55) begin
         // two-byte latin-1, occasionally with a junk second byte
         s.push_back(LEAD_C3);
         if ($urandom_range(0, 9) != 0) begin
            s.push_back(8'($urandom_range(128, 191)));
         end else begin
            s.push_back(8'($urandom_range(0, 255)));
         end
      end else if (pick < 70) begin
         s.push_back(LEAD_E2);
         s.push_back(CONT_80);
         if ($urandom_range(0, 4) != 0) begin
            s.push_back(punct[$urandom_range(0, 6)]);
         end else begin
            s.push_back(8'($urandom_range(0, 255)));
         end
      end else if (pick < 80) begin
         // some other lead byte and its tail, all to be dropped
         do lead = 8'($urandom_range(128, 255)); while (lead == LEAD_C3 || lead == LEAD_E2);
         s.push_back(lead);
         n_cont = $urandom_range(0, 3);
         repeat (n_cont) s.push_back(8'($urandom_range(128, 191)));
      end else if (pick < 90) begin
         // broken E2: anything but 80 after it
         s.push_back(LEAD_E2);
         do lead = 8'($urandom_range(0, 255)); while (lead == CONT_80);
         s.push_back(lead);
      end else begin
         s.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   task automatic send_random_strings(input int n_items);
      byte_queue_type s;
      int      stop_at;
      int      n_pieces;
      stop_at = requests_sent + n_items;
      while (requests_sent < stop_at) begin
         s        = {};
         n_pieces = $urandom_range(1, 4);
         repeat (n_pieces) add_random_piece(s);
         send_string(s);
      end
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // ascii extremes, latin-1 folds, punctuation and malformed sequences at reset limit
   task automatic test_directed_folds();
      // zero byte is an ordinary character
      send_string('{8'h00, 8'h7F});
      // umlaut, sharp s, unmapped code, and a zero byte taken as second byte
      send_string('{LEAD_C3, 8'h84, LEAD_C3, 8'h9F, LEAD_C3, 8'hBF, LEAD_C3, 8'h00});
      // dash and ellipsis
      send_string('{LEAD_E2, CONT_80, PUNCT_EN, LEAD_E2, CONT_80, PUNCT_ELLIP});
      // unknown third byte, E2 without 80 (fresh byte), E2 then a continuation (skip)
      send_string('{LEAD_E2, CONT_80, 8'h41, LEAD_E2, 8'h41, LEAD_E2, 8'h85, 8'h41});
      // four-byte sequence dropped whole, then a lone lead byte closing the string
      send_string('{8'hF0, 8'h9F, 8'h98, CONT_80, 8'h41, LEAD_C3});
   endtask

   // limit at zero, at one, lowered mid-string and cutting a two-letter fold
   task automatic test_char_limit();
      write_char_limit(8'd0);
      send_string('{8'h61, LEAD_C3, 8'hA4});
      write_char_limit(8'd1);
      send_string('{LEAD_E2, CONT_80, PUNCT_ELLIP});
      // string left open while the limit drops below what it already wrote
      write_char_limit(8'd4);
      send_string('{8'h61, 8'h62, 8'h63}, 1'b0);
      write_char_limit(8'd2);
      send_string('{8'h64});
      write_char_limit(8'd3);
      send_string('{LEAD_C3, 8'hA4, LEAD_C3, 8'hB6});
      write_char_limit(8'd255);
   endtask

   // receiver holds off while ellipses keep coming, so the queue fills and req_ready drops
   task automatic test_output_stall();
      hold_asks++;
      repeat (6) send_string('{LEAD_E2, CONT_80, PUNCT_ELLIP});
      // sender pauses until the block has caught up
      wait_all_chars_out();
   endtask

   // back to back on both sides
   task automatic test_no_idling();
      idle_on = 1'b0;
      send_random_strings(30);
      wait_all_chars_out();
      idle_on = 1'b1;
   endtask

   // random strings under a tight, a full and the default limit
   task automatic test_random_strings();
      write_char_limit(8'($urandom_range(0, 6)));
      send_random_strings(RANDOM_ITEMS / 3);
      write_char_limit(8'd255);
      send_random_strings(RANDOM_ITEMS / 3);
      write_char_limit(MAX_OUT_RESET);
      send_random_strings(RANDOM_ITEMS / 3);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      errors        = 0;
      requests_sent = 0;
      idle_on       = 1'b1;
      hold_asks     = 0;
      pred_mode     = DEC_IDLE;
      pred_count    = '0;
      pred_limit    = MAX_OUT_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_folds();
      test_char_limit();
      test_output_stall();
      test_no_idling();
      test_random_strings();

      // let any stray response show up before calling it
      wait_all_chars_out();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("PASS utf8_to_ascii_folder_top");
      end else begin
         $display("FAIL utf8_to_ascii_folder_top");
      end
      $finish;
   end

   // watchdog: far beyond the slowest correct run
   initial begin
      #2000000;
      $display("FAIL utf8_to_ascii_folder_top");
      $finish;
   end

endmodule

FILE: files.f
rtl/u2af_pkg.sv
rtl/u2af_front.sv
rtl/u2af_queue.sv
rtl/u2af_back.sv
rtl/utf8_to_ascii_folder_top.sv
rtl/u2af_checker.sv
bench/tb_utf8_to_ascii_folder_top.sv
